// ===== sv/apc_pkg.sv =====
// Shared types, register indexes and channel arithmetic for the ARGB pixel compositor.
// No dependencies; used by every other file of the block.
package apc_pkg;

  localparam int PixW    = 32;
  localparam int ChanW   = 8;
  localparam int NumChan = PixW / ChanW;
  localparam int CfgIdxW = 2;
  localparam int ProdW   = 2 * ChanW;

  typedef logic [PixW-1:0]  pix_t;
  typedef logic [ChanW-1:0] chan_t;
  typedef logic [ProdW-1:0] prod_t;

  localparam pix_t  AllOnes   = '1;
  localparam chan_t AlphaFull = '1;

  // Register indexes on the write port
  localparam logic [CfgIdxW-1:0] CfgUseSource = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBlendMode = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgColourMul = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgConstAlph = 2'd3;

  typedef struct packed {
    logic  use_source;
    logic  blend_mode;
    pix_t  colour_mul;
    chan_t opacity;
  } cfg_t;

  // Per-stage advance strobes, from the control in the top level
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  // (ch * a) >> 8 on each channel
  function automatic pix_t byte_mul(pix_t c, chan_t a);
    pix_t  r;
    prod_t p;
    r = '0;
    for (int i = 0; i < NumChan; i++) begin
      p = ProdW'(c[i*ChanW +: ChanW]) * ProdW'(a);
      r[i*ChanW +: ChanW] = p[ProdW-1:ChanW];
    end
    return r;
  endfunction

  // (x * y + 255) >> 8 on each channel
  function automatic pix_t sym_mul(pix_t x, pix_t y);
    pix_t          r;
    logic [ProdW:0] p;
    r = '0;
    for (int i = 0; i < NumChan; i++) begin
      p = (ProdW+1)'(x[i*ChanW +: ChanW]) * (ProdW+1)'(y[i*ChanW +: ChanW])
          + (ProdW+1)'(AlphaFull);
      r[i*ChanW +: ChanW] = p[ProdW-1:ChanW];
    end
    return r;
  endfunction

endpackage

// ===== sv/apc_if.sv =====
// Stream interfaces of the ARGB pixel compositor: input item and result item channels.
// Depends on apc_pkg for the pixel type.
interface apc_in_if;
  logic          valid;
  logic          ready;
  apc_pkg::pix_t source_pixel;
  apc_pkg::pix_t dest_pixel;
  logic          last_in;

  modport source (output valid, source_pixel, dest_pixel, last_in, input ready);
  modport sink   (input valid, source_pixel, dest_pixel, last_in, output ready);
endinterface

interface apc_out_if;
  logic          valid;
  logic          ready;
  apc_pkg::pix_t result_pixel;
  logic          last_out;

  modport source (output valid, result_pixel, last_out, input ready);
  modport sink   (input valid, result_pixel, last_out, output ready);
endinterface

// ===== sv/argb_pixel_compositor_top.sv =====
// Top level of the ARGB pixel compositor: config registers, pipeline valid/stall control.
// Depends on apc_pkg, apc_if (apc_in_if, apc_out_if) and apc_datapath.
//
// Usage:
//   Composites premultiplied 32-bit ARGB pixels. Each item on in_i carries a source
//   pixel, the current destination pixel and a span-end flag; each item on out_o is
//   the new destination pixel with the flag passed through. Modes: solid copy, solid
//   over, source copy, source over, chosen by use_source and blend_mode; all apply
//   colour_multiplier and constant_alpha.
//   Channels use valid/ready; an item moves when both are high at a clock edge.
//   Config is written through cfg_we_i/cfg_idx_i/cfg_data_i, one register per cycle,
//   and must only change while no item is in flight.
// Timing:
//   Four register stages (alpha scale, source multiply, channel products, add and
//   output register); an accepted item passes through each in turn before it shows
//   valid on out_o. Throughput is one item per clock while out_o.ready is high.
// Reset:
//   rst_ni (async, active low) empties the pipe and loads the config defaults:
//   solid mode, over blending, multiplier all ones, constant alpha 255.
// Stall:
//   When out_o.ready is low the output holds; stages behind it keep filling bubbles
//   and in_i.ready drops only once every stage holds an item. Nothing is lost or repeated.
module argb_pixel_compositor_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  apc_in_if.sink                       in_i,
  apc_out_if.source                    out_o,
  input  logic                         cfg_we_i,
  input  logic [apc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  apc_pkg::pix_t                cfg_data_i
);

  // Configuration registers
  apc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.use_source <= 1'b0;
      cfg_q.blend_mode <= 1'b1;
      cfg_q.colour_mul <= apc_pkg::AllOnes;
      cfg_q.opacity    <= apc_pkg::AlphaFull;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        apc_pkg::CfgUseSource: cfg_q.use_source <= cfg_data_i[0];
        apc_pkg::CfgBlendMode: cfg_q.blend_mode <= cfg_data_i[0];
        apc_pkg::CfgColourMul: cfg_q.colour_mul <= cfg_data_i;
        apc_pkg::CfgConstAlph: cfg_q.opacity    <= cfg_data_i[apc_pkg::ChanW-1:0];
        default: ;
      endcase
    end
  end

  // Valid bits travel with the stages; a stage advances when it is empty or the one
  // after it is advancing (stage 4: when out_o.ready is high). Stage 4 is the output register.
  logic               v1_q, v2_q, v3_q, v4_q;
  apc_pkg::stage_en_t en;

  assign en.s4 = ~v4_q | out_o.ready;
  assign en.s3 = ~v3_q | en.s4;
  assign en.s2 = ~v2_q | en.s3;
  assign en.s1 = ~v1_q | en.s2;

  assign in_i.ready = en.s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en.s1) v1_q <= in_i.valid;
      if (en.s2) v2_q <= v1_q;
      if (en.s3) v3_q <= v2_q;
      if (en.s4) v4_q <= v3_q;
    end
  end

  apc_datapath u_datapath (
    .clk_i       (clk_i),
    .cfg_i       (cfg_q),
    .en_i        (en),
    .src_pixel_i (in_i.source_pixel),
    .dst_pixel_i (in_i.dest_pixel),
    .last_i      (in_i.last_in),
    .result_o    (out_o.result_pixel),
    .last_o      (out_o.last_out)
  );

  assign out_o.valid = v4_q;

endmodule

// ===== sv/apc_datapath.sv =====
// Four-stage compositing datapath: constant alpha, source multiply, channel blend, final add.
// Depends on apc_pkg; stage strobes come from the top level.
module apc_datapath (
  input  logic               clk_i,
  input  apc_pkg::cfg_t      cfg_i,
  input  apc_pkg::stage_en_t en_i,
  input  apc_pkg::pix_t      src_pixel_i,
  input  apc_pkg::pix_t      dst_pixel_i,
  input  logic               last_i,
  output apc_pkg::pix_t      result_o,
  output logic               last_o
);

  localparam int ChanW   = apc_pkg::ChanW;
  localparam int NumChan = apc_pkg::NumChan;
  localparam int ProdW   = apc_pkg::ProdW;

  logic src_copy;
  assign src_copy = cfg_i.use_source & ~cfg_i.blend_mode;

  // Stage 1: K = color scaled by constant alpha
  apc_pkg::pix_t s1_src_q, s1_dst_q, s1_k_q, s1_k_d;
  logic          s1_last_q;

  assign s1_k_d = (cfg_i.opacity != apc_pkg::AlphaFull) ?
                  apc_pkg::byte_mul(cfg_i.colour_mul, cfg_i.opacity) :
                  cfg_i.colour_mul;

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      s1_src_q  <= src_pixel_i;
      s1_dst_q  <= dst_pixel_i;
      s1_last_q <= last_i;
      s1_k_q    <= s1_k_d;
    end
  end

  // Stage 2: top term T (source times multiplier in copy mode or times K in over mode, or K for solid fill)
  apc_pkg::pix_t s2_t_q, s2_t_d, s2_dst_q, s2_sel;
  logic          s2_last_q;

  assign s2_sel = cfg_i.blend_mode ? s1_k_q : cfg_i.colour_mul;

  always_comb begin
    if (!cfg_i.use_source) begin
      s2_t_d = s1_k_q;
    end else if (s2_sel == apc_pkg::AllOnes) begin
      s2_t_d = s1_src_q;
    end else begin
      s2_t_d = apc_pkg::sym_mul(s1_src_q, s2_sel);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      s2_t_q    <= s2_t_d;
      s2_dst_q  <= s1_dst_q;
      s2_last_q <= s1_last_q;
    end
  end

  // Stage 3: per-channel products; interp for source copy, dest scaling otherwise
  apc_pkg::prod_t        s3_prod_d [NumChan];
  apc_pkg::prod_t        s3_prod_q [NumChan];
  apc_pkg::pix_t         s3_t_q;
  logic                  s3_last_q;
  logic [ChanW:0]        s3_wdst;
  apc_pkg::chan_t        s3_wsrc;

  always_comb begin
    if (src_copy) begin
      s3_wdst = (ChanW+1)'(1 << ChanW) - (ChanW+1)'(cfg_i.opacity);
      s3_wsrc = cfg_i.opacity;
    end else if (!cfg_i.use_source && !cfg_i.blend_mode) begin
      s3_wdst = (ChanW+1)'(apc_pkg::AlphaFull - cfg_i.opacity);
      s3_wsrc = '0;
    end else begin
      s3_wdst = (ChanW+1)'(apc_pkg::AlphaFull - s2_t_q[apc_pkg::PixW-1 -: ChanW]);
      s3_wsrc = '0;
    end
    for (int i = 0; i < NumChan; i++) begin
      s3_prod_d[i] = ProdW'(s2_t_q[i*ChanW +: ChanW]) * ProdW'(s3_wsrc)
                   + ProdW'(s2_dst_q[i*ChanW +: ChanW]) * ProdW'(s3_wdst);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      s3_prod_q <= s3_prod_d;
      s3_t_q    <= s2_t_q;
      s3_last_q <= s2_last_q;
    end
  end

  // Stage 4: gather channel results and add, wrapping at 32 bits; source copy takes T or the blend alone
  apc_pkg::pix_t s4_blend, s4_res_d, s4_res_q;
  logic          s4_last_q;

  always_comb begin
    s4_blend = '0;
    for (int i = 0; i < NumChan; i++) begin
      s4_blend[i*ChanW +: ChanW] = s3_prod_q[i][ProdW-1:ChanW];
    end
    if (src_copy) begin
      s4_res_d = (cfg_i.opacity == apc_pkg::AlphaFull) ? s3_t_q : s4_blend;
    end else begin
      s4_res_d = s3_t_q + s4_blend;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      s4_res_q  <= s4_res_d;
      s4_last_q <= s3_last_q;
    end
  end

  assign result_o = s4_res_q;
  assign last_o   = s4_last_q;

endmodule

// ===== sv/apc_checker.sv =====
// Port-level checks for the ARGB pixel compositor, bound to the top level.
// Depends on apc_pkg and the top level's ports.
module apc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input apc_pkg::pix_t result_pixel_i,
  input logic          last_out_i
);

  // Result holds while the receiver stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(result_pixel_i) && $stable(last_out_i))
    else $error("result item changed while stalled");

  // A ready receiver never back-pressures the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input stalled with receiver ready");

  // With the receiver kept ready, an accepted item reaches the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
      |=> out_valid_i)
    else $error("pipeline latency exceeded");

endmodule

bind argb_pixel_compositor_top apc_checker u_apc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .result_pixel_i (out_o.result_pixel),
  .last_out_i     (out_o.last_out)
);
